### hdl/spq_pkg.sv
// Shared types, sizes and codes for the stable priority queue.
package spq_pkg;

	// Queue geometry and stored field widths.
	localparam int CAPACITY  = 16;
	localparam int JOB_BITS  = 16;
	localparam int PRIO_BITS = 8;

	// Entry counter holds zero up to CAPACITY.
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Result field widths.
	localparam int OCC_W    = 5;
	localparam int STATUS_W = 2;

	// Stream word widths, padded to whole bytes.
	localparam int S_TDATA_W = ((JOB_BITS + PRIO_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((JOB_BITS + OCC_W + 7) / 8) * 8;

	// Request kinds carried on the input tuser.
	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	// Result status codes carried on the output tuser.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One stored queue entry.
	typedef struct packed {
		logic [JOB_BITS-1:0]  job;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t item;
	} cell_ctl_t;

endpackage

### hdl/spq_cell.sv
// One cell of the sorted shift-register queue: holds one entry.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               valid,
	input  logic               left_lower,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               lower
);
	import spq_pkg::*;

	entry_t entry_q;
	entry_t entry_d;

	// This cell holds a strictly lower priority than the new item, or is empty.
	// Along the row the flag is clear up to the insertion point and set after it.
	assign lower = !valid || (entry_q.prio < ctl.item.prio);

	// On insert the first lower cell takes the new item and the rest shift
	// right; on removal every cell takes its right neighbor's entry.
	always_comb begin
		entry_d = entry_q;
		if (ctl.enq && lower) begin
			if (left_lower) begin
				entry_d = left_entry;
			end else begin
				entry_d = ctl.item;
			end
		end else if (ctl.deq) begin
			entry_d = right_entry;
		end
	end

	// Payload register; validity comes from the count, so no reset here.
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

### hdl/stable_priority_queue.sv
// Top level of the stable priority queue: cell row, count and result register.
//
//   channel  dir  tdata (low bit up)             tuser
//   s_*      in   job_number, job_priority       req_type
//   m_*      out  job_out, occupancy             status
//
// Each result word is registered and appears on the output the cycle after
// acceptance, and a new request is taken every cycle while the output
// register is empty or being drained. The whole cell row compares and shifts
// in parallel on acceptance. Reset clears the entry count and the output
// valid; the cells need no clearing. A stalled output holds its word and
// blocks further requests until it is taken.
module stable_priority_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	// Requests.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,  // job_number, job_priority
	input  logic                            s_tuser,  // req_type
	// Results.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,  // job_out, occupancy
	output logic [spq_pkg::STATUS_W-1:0]    m_tuser   // status
);
	import spq_pkg::*;

	logic                 accept;
	logic                 is_deq;
	logic                 full;
	logic                 empty;
	cell_ctl_t            ctl;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	status_t              status_d;
	logic [JOB_BITS-1:0]  job_out_d;
	logic                 m_valid_q;
	status_t              status_q;
	logic [JOB_BITS-1:0]  job_out_q;
	logic [OCC_W-1:0]     occ_q;
	entry_t               cell_entry [CAPACITY];
	logic                 cell_lower [CAPACITY];
	logic                 cell_valid [CAPACITY];

	// Handshake and request decode.
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_deq   = (req_t'(s_tuser) == REQ_DEQ);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// Command broadcast to the cell row.
	always_comb begin
		ctl.enq       = accept && !is_deq && !full;
		ctl.deq       = accept && is_deq && !empty;
		ctl.item.job  = s_tdata[JOB_BITS-1:0];
		ctl.item.prio = s_tdata[JOB_BITS +: PRIO_BITS];
	end

	// Next count and result fields.
	always_comb begin
		count_d   = count_q;
		status_d  = ST_OK;
		job_out_d = '0;
		if (is_deq) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				job_out_d = cell_entry[0].job;
				count_d   = count_q - 1'b1;
			end
		end else begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + 1'b1;
			end
		end
	end

	// Row of cells; each one sees its neighbors' entries.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_entry;
		entry_t right_entry;
		logic   left_lower;

		assign cell_valid[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_entry = ctl.item;
			assign left_lower = 1'b0;
		end else begin : g_body
			assign left_entry = cell_entry[i-1];
			assign left_lower = cell_lower[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_mid
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.valid       (cell_valid[i]),
			.left_lower  (left_lower),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.lower       (cell_lower[i])
		);
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= accept;
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			job_out_q <= job_out_d;
			occ_q     <= OCC_W'(count_d);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_TDATA_W'({occ_q, job_out_q});

endmodule
